@@ rtl/svm_pkg.sv @@
// package with opcodes, fault codes, sizes and sequencer states of the stack vm executor
`default_nettype none
package svm_pkg;
  localparam int RamBytes = 16384;
  localparam int RamAw = $clog2(RamBytes);
  localparam int StackEntries = 255;
  localparam int StackAw = $clog2(StackEntries);
  localparam int CountW = $clog2(StackEntries + 1);

  localparam logic [7:0] OP_EXIT = 8'd0;
  localparam logic [7:0] OP_STB = 8'd1;
  localparam logic [7:0] OP_CPIN = 8'd2;
  localparam logic [7:0] OP_STW = 8'd3;
  localparam logic [7:0] OP_CPOUT = 8'd4;
  localparam logic [7:0] OP_STC = 8'd5;
  localparam logic [7:0] OP_ADD = 8'd10;
  localparam logic [7:0] OP_SUB = 8'd11;
  localparam logic [7:0] OP_MUL = 8'd12;
  localparam logic [7:0] OP_DIV = 8'd13;
  localparam logic [7:0] OP_MOD = 8'd14;
  localparam logic [7:0] OP_SHL = 8'd15;
  localparam logic [7:0] OP_SHR = 8'd16;
  localparam logic [7:0] OP_GT = 8'd17;
  localparam logic [7:0] OP_EQ = 8'd18;
  localparam logic [7:0] OP_LT = 8'd19;
  localparam logic [7:0] OP_NOT = 8'd20;
  localparam logic [7:0] OP_OR = 8'd22;
  localparam logic [7:0] OP_XOR = 8'd23;
  localparam logic [7:0] OP_AND = 8'd24;
  localparam logic [7:0] OP_NE = 8'd25;
  localparam logic [7:0] OP_GE = 8'd26;
  localparam logic [7:0] OP_LE = 8'd27;
  localparam logic [7:0] OP_JREL = 8'd30;
  localparam logic [7:0] OP_JT = 8'd31;
  localparam logic [7:0] OP_JF = 8'd32;
  localparam logic [7:0] OP_PUSHW = 8'd40;
  localparam logic [7:0] OP_PUSHB = 8'd41;
  localparam logic [7:0] OP_PUSHI = 8'd42;
  localparam logic [7:0] OP_POPB = 8'd43;
  localparam logic [7:0] OP_POPW = 8'd44;
  localparam logic [7:0] OP_PRINT = 8'd45;
  localparam logic [7:0] OP_READ = 8'd46;
  localparam logic [7:0] OP_ALT = 8'd60;

  localparam logic [2:0] F_NONE = 3'd0;
  localparam logic [2:0] F_OVER = 3'd1;
  localparam logic [2:0] F_UNDER = 3'd2;
  localparam logic [2:0] F_DIV0 = 3'd3;
  localparam logic [2:0] F_OPC = 3'd4;
  localparam logic [2:0] F_ADDR = 3'd5;
  localparam logic [2:0] F_MODE = 3'd6;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DEC, S_STK1, S_STK2, S_RD0, S_RD1, S_RDW, S_PTR,
    S_RDO, S_WR0, S_WR1, S_ALU, S_DIVS, S_DIVF, S_DONE
  } state_t;

  // request to the shared alu
  typedef struct packed {
    logic [7:0] op;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic start;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] res;
    logic busy;
  } alu_rsp_t;
endpackage
`default_nettype wire

@@ rtl/svm_if.sv @@
// valid/ready channel interfaces of the stack vm executor
`default_nettype none
interface svm_in_if;
  logic valid;
  logic ready;
  logic [7:0] func;
  logic [31:0] instr_addr;
  logic signed [15:0] addr_a;
  logic signed [15:0] addr_b;
  logic signed [15:0] offset;
  logic signed [7:0] imm8;
  logic [15:0] imm16;
  logic [31:0] jump_target;
  logic signed [8:0] char_in;
  modport source(output valid, func, instr_addr, addr_a, addr_b, offset, imm8, imm16,
    jump_target, char_in, input ready);
  modport sink(input valid, func, instr_addr, addr_a, addr_b, offset, imm8, imm16,
    jump_target, char_in, output ready);
endinterface

interface svm_out_if;
  logic valid;
  logic ready;
  logic [31:0] next_addr;
  logic [7:0] char_out;
  logic char_valid;
  logic halted;
  logic signed [7:0] exit_code;
  logic [2:0] fault;
  modport source(output valid, next_addr, char_out, char_valid, halted, exit_code, fault,
    input ready);
  modport sink(input valid, next_addr, char_out, char_valid, halted, exit_code, fault,
    output ready);
endinterface
`default_nettype wire

@@ rtl/svm_alu.sv @@
// shared alu: combinational ops with a registered result plus a bit-serial signed divider
`default_nettype none
module svm_alu (
  input wire logic clk,
  input wire logic rst,
  input svm_pkg::alu_req_t req,
  output svm_pkg::alu_rsp_t rsp
);
  import svm_pkg::*;
  logic [4:0] cnt;
  logic [15:0] quo, dvs;
  logic [16:0] rem;
  logic negq, negr, is_mod, busy;
  logic [15:0] res, comb_res;
  logic [16:0] trial;
  logic [31:0] prod;
  logic [15:0] ua, ub;

  assign ua = req.a[15] ? 16'(-req.a) : req.a;
  assign ub = req.b[15] ? 16'(-req.b) : req.b;
  assign prod = 32'(req.b) * 32'(req.a);
  assign trial = {rem[15:0], quo[15]} - {1'b0, dvs};

  always_comb begin
    comb_res = '0;
    case (req.op)
      OP_ADD: comb_res = req.b + req.a;
      OP_SUB: comb_res = req.b - req.a;
      OP_MUL: comb_res = prod[15:0];
      OP_SHL: comb_res = (req.a >= 16) ? 16'd0 : 16'(req.b << req.a[3:0]);
      OP_SHR: comb_res = (req.a >= 16) ? {16{req.b[15]}} : 16'(req.b >>> req.a[3:0]);
      OP_GT: comb_res = {15'd0, req.b > req.a};
      OP_EQ: comb_res = {15'd0, req.b == req.a};
      OP_LT: comb_res = {15'd0, req.b < req.a};
      OP_OR: comb_res = {15'd0, req.b == 16'sd1 || req.a == 16'sd1};
      OP_XOR: comb_res = req.b ^ req.a;
      OP_AND: comb_res = {15'd0, req.b == 16'sd1 && req.a == 16'sd1};
      OP_NE: comb_res = {15'd0, req.b != req.a};
      OP_GE: comb_res = {15'd0, req.b >= req.a};
      OP_LE: comb_res = {15'd0, req.b <= req.a};
      default: comb_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start && (req.op == OP_DIV || req.op == OP_MOD)) begin
      busy <= 1'b1;
      cnt <= 5'd16;
      quo <= ub;
      dvs <= ua;
      rem <= '0;
      negq <= req.a[15] ^ req.b[15];
      negr <= req.b[15];
      is_mod <= req.op == OP_MOD;
    end else if (req.start) begin
      res <= comb_res;
    end else if (busy) begin
      if (cnt == 5'd0) begin
        busy <= 1'b0;
        if (is_mod) res <= negr ? 16'(-rem[15:0]) : rem[15:0];
        else res <= negq ? 16'(-quo) : quo;
      end else begin
        cnt <= cnt - 5'd1;
        if (!trial[16]) begin
          rem <= trial;
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= {rem[15:0], quo[15]};
          quo <= {quo[14:0], 1'b0};
        end
      end
    end
  end
  assign rsp.res = res;
  assign rsp.busy = busy;
endmodule
`default_nettype wire

@@ rtl/stack_vm_instruction_executor.sv @@
// top level of the stack vm executor: sequencer, data ram and operand stack
// One instruction per input transaction. After reset a clearing pass writes the
// 16384-byte data ram to zero, one byte a cycle, before the first input is taken.
// Every instruction walks the same chain of sequencer states, from decode through
// stack reads, ram reads, ram writes and the alu to the result state. Divide and
// modulo stay in the shared alu for its 16-step restoring divider, and the
// sequencer waits in S_DIVS while the divider is busy.
// A result is held in an output register until taken; the next input is taken after that.
`default_nettype none
module stack_vm_instruction_executor (
  input wire logic clk,
  input wire logic rst,
  svm_in_if.sink in_ch,
  svm_out_if.source out_ch
);
  import svm_pkg::*;
  state_t state, state_next;
  logic [7:0] ram [RamBytes];
  logic [15:0] stk [StackEntries];
  logic [RamAw-1:0] clr;
  logic [CountW-1:0] cnt;
  logic stopped;
  logic [7:0] func;
  logic [31:0] ia, jt;
  logic signed [15:0] aa, ab, off;
  logic signed [7:0] i8;
  logic [15:0] i16, tos, nos, wv;
  logic signed [8:0] ci;
  logic [7:0] rdat, lo;
  logic [RamAw-1:0] raddr, waddr;
  logic [7:0] wdat;
  logic we;
  logic [StackAw-1:0] sa;
  logic [16:0] ptr;
  logic signed [17:0] pt, ot;
  logic [31:0] nxt;
  logic [2:0] flt;
  logic [7:0] co;
  logic cv, hl;
  logic [7:0] ec;
  alu_req_t areq;
  alu_rsp_t arsp;

  svm_alu u_alu (.clk(clk), .rst(rst), .req(areq), .rsp(arsp));

  function automatic logic okr(input logic signed [17:0] a, input int n);
    return a >= 0 && (a + 18'(n)) <= 18'(RamBytes);
  endfunction

  logic is_bin;
  assign is_bin = (func >= OP_ADD && func <= OP_LT) || (func >= OP_OR && func <= OP_LE);
  assign pt = 18'(signed'(ptr[15:0])) + 18'(off);
  assign ot = 18'(ab) + 18'(off);

  assign in_ch.ready = state == S_IDLE;
  assign out_ch.valid = state == S_DONE;
  assign out_ch.next_addr = nxt;
  assign out_ch.char_out = co;
  assign out_ch.char_valid = cv;
  assign out_ch.halted = hl;
  assign out_ch.exit_code = ec;
  assign out_ch.fault = flt;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr == RamAw'(RamBytes - 1)) state_next = S_IDLE;
      S_IDLE: if (in_ch.valid) state_next = S_DEC;
      S_DEC: state_next = S_STK1;
      S_STK1: state_next = S_STK2;
      S_STK2: state_next = S_RD0;
      S_RD0: state_next = S_RD1;
      S_RD1: state_next = S_RDW;
      S_RDW: state_next = S_PTR;
      S_PTR: state_next = S_RDO;
      S_RDO: state_next = S_WR0;
      S_WR0: state_next = S_WR1;
      S_WR1: state_next = S_ALU;
      S_ALU: state_next = S_DIVS;
      S_DIVS: state_next = arsp.busy ? S_DIVS : S_DIVF;
      S_DIVF: state_next = S_DONE;
      S_DONE: if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    areq.op = func;
    areq.a = signed'(tos);
    areq.b = signed'(nos);
    areq.start = state == S_ALU && flt == F_NONE && is_bin;
  end

  always_ff @(posedge clk) begin
    if (we) ram[waddr] <= wdat;
    rdat <= ram[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdat = '0;
    raddr = aa[RamAw-1:0];
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr;
      end
      S_RD0: raddr = aa[RamAw-1:0];
      S_RD1: raddr = RamAw'(aa + 16'sd1);
      S_PTR, S_RDO: raddr = (func == OP_CPOUT) ? pt[RamAw-1:0] : ot[RamAw-1:0];
      S_WR0: if (flt == F_NONE && !hl) begin
        case (func)
          OP_STB: begin we = 1'b1; waddr = aa[RamAw-1:0]; wdat = i8; end
          OP_STW: begin we = 1'b1; waddr = aa[RamAw-1:0]; wdat = i16[7:0]; end
          OP_POPB, OP_POPW: begin we = 1'b1; waddr = aa[RamAw-1:0]; wdat = tos[7:0]; end
          OP_CPIN: begin we = 1'b1; waddr = pt[RamAw-1:0]; wdat = rdat; end
          OP_CPOUT: begin we = 1'b1; waddr = ot[RamAw-1:0]; wdat = rdat; end
          OP_STC: begin we = 1'b1; waddr = pt[RamAw-1:0]; wdat = i8; end
          default: we = 1'b0;
        endcase
      end
      S_WR1: if (flt == F_NONE && !hl) begin
        case (func)
          OP_STW: begin we = 1'b1; waddr = RamAw'(aa + 16'sd1); wdat = i16[15:8]; end
          OP_POPW: begin we = 1'b1; waddr = RamAw'(aa + 16'sd1); wdat = tos[15:8]; end
          default: we = 1'b0;
        endcase
      end
      default: we = 1'b0;
    endcase
  end

  assign sa = (state == S_DEC) ? StackAw'(cnt - CountW'(1)) : StackAw'(cnt - CountW'(2));
  assign wv = {rdat, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      cnt <= '0;
      stopped <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: clr <= clr + RamAw'(1);
        S_IDLE: if (in_ch.valid) begin
          func <= in_ch.func; ia <= in_ch.instr_addr; aa <= in_ch.addr_a;
          ab <= in_ch.addr_b; off <= in_ch.offset; i8 <= in_ch.imm8;
          i16 <= in_ch.imm16; jt <= in_ch.jump_target; ci <= in_ch.char_in;
          flt <= F_NONE; hl <= stopped; co <= '0; cv <= 1'b0; ec <= '0;
          nxt <= in_ch.instr_addr;
        end
        S_DEC: begin
          tos <= stk[sa];
          if (!hl) begin
            case (func)
              OP_EXIT: begin hl <= 1'b1; ec <= i8; end
              OP_STB, OP_STW: if (!okr(18'(aa), func == OP_STB ? 1 : 2)) flt <= F_ADDR;
              OP_CPIN, OP_CPOUT, OP_STC: if (!okr(18'(aa), 2)) flt <= F_ADDR;
              OP_PUSHW, OP_PUSHB, OP_PUSHI, OP_READ:
                if (cnt >= CountW'(StackEntries)) flt <= F_OVER;
                else if ((func == OP_PUSHW && !okr(18'(aa), 2)) ||
                         (func == OP_PUSHB && !okr(18'(aa), 1))) flt <= F_ADDR;
              OP_POPB, OP_POPW, OP_PRINT, OP_JREL, OP_JT, OP_JF:
                if (cnt == '0) flt <= F_UNDER;
                else if ((func == OP_POPW && !okr(18'(aa), 2)) ||
                         (func == OP_POPB && !okr(18'(aa), 1))) flt <= F_ADDR;
              OP_NOT: if (cnt == '0) flt <= F_UNDER;
              OP_ALT: flt <= F_MODE;
              default:
                if (is_bin) begin
                  if (cnt < CountW'(2)) flt <= F_UNDER;
                end else flt <= F_OPC;
            endcase
          end
        end
        S_STK1: begin
          nos <= stk[sa];
          if (is_bin && flt == F_NONE && !hl) begin
            if ((func == OP_DIV || func == OP_MOD) && tos == '0) flt <= F_DIV0;
            if ((func == OP_SHL || func == OP_SHR) && tos[15]) flt <= F_MODE;
          end
        end
        S_RD1: lo <= rdat;
        S_RDW: ptr <= {1'b0, wv};
        S_PTR: if (flt == F_NONE && !hl && (func == OP_CPIN || func == OP_CPOUT ||
                   func == OP_STC)) begin
          if (!okr(pt, 1) || (func != OP_STC && !okr(ot, 1))) flt <= F_ADDR;
        end
        S_DIVF: begin
          if (flt != F_NONE) begin
            hl <= 1'b1; nxt <= ia;
          end else if (!hl) begin
            case (func)
              OP_EXIT: nxt <= ia;
              OP_STB: nxt <= ia + 32'd4;
              OP_STW: nxt <= ia + 32'd5;
              OP_CPIN, OP_CPOUT: nxt <= ia + 32'd7;
              OP_STC: nxt <= ia + 32'd6;
              OP_PUSHW, OP_PUSHB, OP_PUSHI, OP_READ: begin
                nxt <= ia + ((func == OP_READ) ? 32'd1 : 32'd3);
                stk[cnt[StackAw-1:0]] <= (func == OP_PUSHI) ? i16 :
                  (func == OP_READ) ? 16'(ci) :
                  (func == OP_PUSHW) ? ptr[15:0] : {{8{lo[7]}}, lo};
                cnt <= cnt + CountW'(1);
              end
              OP_POPB, OP_POPW: begin nxt <= ia + 32'd3; cnt <= cnt - CountW'(1); end
              OP_PRINT: begin
                nxt <= ia + 32'd1; co <= tos[7:0]; cv <= 1'b1; cnt <= cnt - CountW'(1);
              end
              OP_JREL: begin
                nxt <= (tos == 16'd1) ? ia + 32'd1 + 32'(i8) : ia + 32'd2;
                cnt <= cnt - CountW'(1);
              end
              OP_JT: begin nxt <= (tos == 16'd1) ? jt : ia + 32'd5; cnt <= cnt - CountW'(1); end
              OP_JF: begin nxt <= (tos != 16'd1) ? jt : ia + 32'd5; cnt <= cnt - CountW'(1); end
              OP_NOT: begin
                nxt <= ia + 32'd1;
                stk[StackAw'(cnt - CountW'(1))] <= (tos == 16'd1) ? 16'd0 : 16'd1;
              end
              default: begin
                nxt <= ia + 32'd1;
                stk[StackAw'(cnt - CountW'(2))] <= arsp.res;
                cnt <= cnt - CountW'(1);
              end
            endcase
          end
          if (hl || flt != F_NONE) stopped <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/svm_checker.sv @@
// port-level checker for the stack vm executor and its bind
`default_nettype none
module svm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic halted,
  input wire logic [2:0] fault,
  input wire logic char_valid,
  input wire logic signed [7:0] exit_code
);
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while result pending");
  a_flt: assert property (@(posedge clk) disable iff (rst) out_valid && fault != 3'd0 |-> halted)
    else $error("fault without halt");
  a_chr: assert property (@(posedge clk) disable iff (rst) out_valid && char_valid |-> !halted)
    else $error("print on halt");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fault) && $stable(exit_code))
    else $error("result dropped");
endmodule

bind stack_vm_instruction_executor svm_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .halted(out_ch.halted),
  .fault(out_ch.fault), .char_valid(out_ch.char_valid), .exit_code(out_ch.exit_code)
);
`default_nettype wire
